@@ rtl/njs_pkg.sv @@
// types, constants and key selection shared by the job scheduler modules
`timescale 1ns / 1ps

package njs_pkg;

  localparam int unsigned ARR_W   = 16;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned TIME_W  = 22;
  localparam int unsigned WAIT_W  = 27;
  localparam int unsigned OIDX_W  = 5;
  localparam int unsigned MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_IDLE = 1'b1;

  // arrival sits in the low bits, matching the input word layout
  typedef struct packed {
    logic [PRI_W-1:0]   pri;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arr;
  } job_t;

  function automatic logic [KEY_W-1:0] mode_key(input job_t j, input logic [MODE_W-1:0] m);
    logic [KEY_W-1:0] k;
    case (m)
      MODE_FCFS: k = j.arr;
      MODE_SJF:  k = j.burst;
      default:   k = {{(KEY_W-PRI_W){1'b0}}, j.pri};
    endcase
    return k;
  endfunction

endpackage

@@ rtl/njs_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module njs_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/njs_cmp.sv @@
// shared compare unit: does the candidate job beat the current best
`timescale 1ns / 1ps

module njs_cmp
  import njs_pkg::*;
(
  input  job_t              cand_i,
  input  job_t              best_i,
  input  logic [TIME_W-1:0] cur_time_i,
  input  logic [MODE_W-1:0] mode_i,
  output logic              beats_o
);

  logic             cand_in, best_in;
  logic [KEY_W-1:0] p1, p2, s1, s2;

  always_comb begin
    cand_in = {{(TIME_W-ARR_W){1'b0}}, cand_i.arr} <= cur_time_i;
    best_in = {{(TIME_W-ARR_W){1'b0}}, best_i.arr} <= cur_time_i;
    if (cand_in) begin
      p1 = mode_key(cand_i, mode_i);
      p2 = mode_key(best_i, mode_i);
      s1 = cand_i.arr;
      s2 = best_i.arr;
    end else begin
      // nobody arrived: earliest arrival first, then the mode key
      p1 = cand_i.arr;
      p2 = best_i.arr;
      s1 = mode_key(cand_i, mode_i);
      s2 = mode_key(best_i, mode_i);
    end
    if (cand_in != best_in) begin
      beats_o = cand_in;
    end else if (p1 != p2) begin
      beats_o = p1 < p2;
    end else begin
      beats_o = s1 < s2;
    end
  end

endmodule

@@ rtl/nonpreemptive_job_scheduler.sv @@
// non-preemptive fcfs / sjf / priority scheduler top level
//
//  channel   dir  handshake            contents
//  s_axis    in   tvalid/tready        job word, tlast starts the run
//  m_axis    out  tvalid/tready        interval word, tuser = kind, tlast = final
//  cfg       in   cfg_we_i             policy mode
//
// each accepted job word is written to the job ram while it has room; the last one starts the schedule
// each pick scans the n loaded jobs through the job ram and one compare unit,
// then emits the picked job's interval, preceded by an idle interval when it has not yet arrived
// input is held off until the run ends
// output stalls hold the sequencer; reset clears counters, flags and the clock
`timescale 1ns / 1ps

module nonpreemptive_job_scheduler
  import njs_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // arrival_time[15:0], burst_length[31:16], job_priority[39:32]
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // job_index[4:0], start_time[26:5], end_time[48:27], total_wait[75:49], zeros
  output logic [79:0] m_axis_tdata,
  // interval_kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JOBS);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [MODE_W-1:0]   mode_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    iss_q, iss_d;
  logic                pend_q, pend_d;
  logic [IDX_W-1:0]    rd_idx_q, rd_idx_d;
  logic [MAX_JOBS-1:0] done_q, done_d;
  logic [TIME_W-1:0]   cur_q, cur_d;
  logic [WAIT_W-1:0]   wait_q, wait_d;
  logic                best_vld_q, best_vld_d;
  job_t                best_q, best_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;

  logic                out_vld_q, out_vld_d;
  logic                out_kind_q, out_kind_d;
  logic [OIDX_W-1:0]   out_idx_q, out_idx_d;
  logic [TIME_W-1:0]   out_start_q, out_start_d;
  logic [TIME_W-1:0]   out_end_q, out_end_d;
  logic [WAIT_W-1:0]   out_wait_q, out_wait_d;
  logic                out_last_q, out_last_d;

  logic                load_acc;
  logic                ram_we;
  logic                ram_re;
  job_t                ram_rdata;
  logic                beats;
  logic                take;
  logic                slot_free;
  logic [TIME_W-1:0]   best_arr_ext;
  logic [TIME_W-1:0]   run_end;
  logic [TIME_W-1:0]   job_wait;
  logic [WAIT_W-1:0]   wait_new;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign load_acc      = s_axis_tvalid && s_axis_tready;
  assign ram_we        = load_acc && (cnt_q < MAX_CNT);
  assign ram_re        = (state_q == ST_SCAN) && (iss_q != cnt_q);

  njs_ram #(
    .WIDTH ($bits(job_t)),
    .DEPTH (MAX_JOBS)
  ) u_jobs (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (iss_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  njs_cmp u_cmp (
    .cand_i     (ram_rdata),
    .best_i     (best_q),
    .cur_time_i (cur_q),
    .mode_i     (mode_q),
    .beats_o    (beats)
  );

  assign take         = pend_q && !done_q[rd_idx_q] && (!best_vld_q || beats);
  assign slot_free    = !out_vld_q || m_axis_tready;
  assign best_arr_ext = {{(TIME_W-ARR_W){1'b0}}, best_q.arr};
  assign run_end      = cur_q + {{(TIME_W-BURST_W){1'b0}}, best_q.burst};
  assign job_wait     = cur_q - best_arr_ext;
  assign wait_new     = wait_q + {{(WAIT_W-TIME_W){1'b0}}, job_wait};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    iss_d       = iss_q;
    pend_d      = 1'b0;
    rd_idx_d    = rd_idx_q;
    done_d      = done_q;
    cur_d       = cur_q;
    wait_d      = wait_q;
    best_vld_d  = best_vld_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_idx_d   = out_idx_q;
    out_start_d = out_start_q;
    out_end_d   = out_end_q;
    out_wait_d  = out_wait_q;
    out_last_d  = out_last_q;

    // compare stage works on the registered ram read, tracked by pend_q and rd_idx_q
    if (take) begin
      best_vld_d = 1'b1;
      best_d     = ram_rdata;
      best_idx_d = rd_idx_q;
    end

    case (state_q)
      ST_LOAD: begin
        if (load_acc) begin
          if (ram_we) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (s_axis_tlast) begin
            rem_d      = ram_we ? cnt_q + 1'b1 : cnt_q;
            iss_d      = '0;
            best_vld_d = 1'b0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (iss_q != cnt_q) begin
          pend_d   = 1'b1;
          rd_idx_d = iss_q[IDX_W-1:0];
          iss_d    = iss_q + 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          if (best_arr_ext > cur_q) begin
            out_kind_d  = KIND_IDLE;
            out_idx_d   = '0;
            out_start_d = cur_q;
            out_end_d   = best_arr_ext;
            out_wait_d  = '0;
            out_last_d  = 1'b0;
            cur_d       = best_arr_ext;
          end else begin
            out_kind_d  = KIND_RUN;
            out_idx_d   = OIDX_W'(best_idx_q);
            out_start_d = cur_q;
            out_end_d   = run_end;
            done_d[best_idx_q] = 1'b1;
            if (rem_q == CNT_W'(1)) begin
              out_wait_d = wait_new;
              out_last_d = 1'b1;
              done_d     = '0;
              cnt_d      = '0;
              cur_d      = '0;
              wait_d     = '0;
              state_d    = ST_LOAD;
            end else begin
              out_wait_d = '0;
              out_last_d = 1'b0;
              cur_d      = run_end;
              wait_d     = wait_new;
              rem_d      = rem_q - 1'b1;
              iss_d      = '0;
              best_vld_d = 1'b0;
              state_d    = ST_SCAN;
            end
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      mode_q     <= MODE_FCFS;
      cnt_q      <= '0;
      rem_q      <= '0;
      iss_q      <= '0;
      pend_q     <= 1'b0;
      rd_idx_q   <= '0;
      done_q     <= '0;
      cur_q      <= '0;
      wait_q     <= '0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      cnt_q      <= cnt_d;
      rem_q      <= rem_d;
      iss_q      <= iss_d;
      pend_q     <= pend_d;
      rd_idx_q   <= rd_idx_d;
      done_q     <= done_d;
      cur_q      <= cur_d;
      wait_q     <= wait_d;
      best_vld_q <= best_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    out_kind_q  <= out_kind_d;
    out_idx_q   <= out_idx_d;
    out_start_q <= out_start_d;
    out_end_q   <= out_end_d;
    out_wait_q  <= out_wait_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_wait_q, out_end_q, out_start_q, out_idx_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
